// ===== rtl/hlx_pkg.sv =====
// Package for the href link extractor: transaction structs, scan phase codes,
// character constants and small matching helpers.
// Depends on nothing; used by hlx_scan and html_href_link_extractor.
`default_nettype none

package hlx_pkg;

	// Field widths of the result transaction
	localparam int OFFSET_BITS = 24;
	localparam int LENGTH_BITS = 12;

	// Number of letters in "javascript"
	localparam logic [3:0] SCRIPT_LEN = 4'd10;

	// Character codes
	localparam logic [7:0] CH_LT    = 8'h3C; // '<'
	localparam logic [7:0] CH_GT    = 8'h3E; // '>'
	localparam logic [7:0] CH_EQ    = 8'h3D; // '='
	localparam logic [7:0] CH_HASH  = 8'h23; // '#'
	localparam logic [7:0] CH_DQ    = 8'h22; // '"'
	localparam logic [7:0] CH_SQ    = 8'h27; // '\''
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_A_LO  = 8'h61; // 'a'
	localparam logic [7:0] CH_A_UP  = 8'h41; // 'A'
	localparam logic [7:0] CH_H_LO  = 8'h68; // 'h'
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LT,
		PH_SP1,
		PH_KEY,
		PH_SP2,
		PH_SP3,
		PH_LINK
	} scan_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] link_start;
		logic [LENGTH_BITS-1:0] link_length;
		logic                   link_quoted;
	} link_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB);
	endfunction

	function automatic logic is_quote(input logic [7:0] b);
		return (b == CH_DQ) || (b == CH_SQ);
	endfunction

	// Lower-case letters of "href"
	function automatic logic [7:0] href_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = 8'h68;
			2'd1:    c = 8'h72;
			2'd2:    c = 8'h65;
			default: c = 8'h66;
		endcase
		return c;
	endfunction

	// Lower-case letters of "javascript"
	function automatic logic [7:0] script_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h6A;
			4'd1:    c = 8'h61;
			4'd2:    c = 8'h76;
			4'd3:    c = 8'h61;
			4'd4:    c = 8'h73;
			4'd5:    c = 8'h63;
			4'd6:    c = 8'h72;
			4'd7:    c = 8'h69;
			4'd8:    c = 8'h70;
			4'd9:    c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Phase after a mismatch: a '<' opens a new tag
	function automatic scan_phase_t rescan(input logic [7:0] b);
		return (b == CH_LT) ? PH_LT : PH_IDLE;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hlx_scan.sv =====
// Byte scanner for the href link extractor: phase register, link tracking
// registers and the combinational next-state and emit logic.
// Depends on hlx_pkg.
`default_nettype none

module hlx_scan (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             take,
	input  wire hlx_pkg::item_t item,
	output logic            res_valid,
	output hlx_pkg::link_t  res
);
	import hlx_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	scan_phase_t            ph_q, ph_d;
	logic [OFFSET_BITS-1:0] off_q;
	logic [OFFSET_BITS-1:0] st_q, st_d;
	logic [LENGTH_BITS-1:0] run_q, run_d;
	logic                   qt_q, qt_d;
	logic [1:0]             kp_q, kp_d;
	logic [3:0]             sp_q, sp_d;
	logic                   sm_q, sm_d;
	logic                   hf_q, hf_d;

	logic [7:0] b;
	logic [7:0] b_lc;
	logic       add_char;
	logic       term_hit;
	logic       is_script;
	logic       emit_hit;

	assign b    = item.data_byte;
	assign b_lc = item.data_byte | CASE_BIT;

	// Next state for one byte
	always_comb begin
		ph_d     = ph_q;
		st_d     = st_q;
		run_d    = run_q;
		qt_d     = qt_q;
		kp_d     = kp_q;
		sp_d     = sp_q;
		sm_d     = sm_q;
		hf_d     = hf_q;
		add_char = 1'b0;
		term_hit = 1'b0;

		case (ph_q)
			PH_LT: begin
				if (b == CH_A_LO || b == CH_A_UP) begin
					ph_d = PH_SP1;
				end else begin
					ph_d = rescan(b);
				end
			end
			PH_SP1: begin
				if (is_blank(b)) begin
					ph_d = PH_SP1;
				end else if (b_lc == CH_H_LO) begin
					kp_d = 2'd1;
					ph_d = PH_KEY;
				end else begin
					ph_d = rescan(b);
				end
			end
			PH_KEY: begin
				if (b_lc == href_char(kp_q)) begin
					if (kp_q == 2'd3) begin
						kp_d = 2'd0;
						ph_d = PH_SP2;
					end else begin
						kp_d = kp_q + 2'd1;
					end
				end else begin
					kp_d = 2'd0;
					ph_d = rescan(b);
				end
			end
			PH_SP2: begin
				if (is_blank(b)) begin
					ph_d = PH_SP2;
				end else if (b == CH_EQ) begin
					ph_d = PH_SP3;
				end else begin
					ph_d = rescan(b);
				end
			end
			PH_SP3: begin
				if (is_blank(b)) begin
					ph_d = PH_SP3;
				end else if (b == CH_GT) begin
					ph_d = PH_IDLE;
				end else begin
					// open a link; an unquoted one starts with this byte
					run_d    = '0;
					qt_d     = is_quote(b);
					sp_d     = '0;
					sm_d     = 1'b0;
					hf_d     = 1'b0;
					ph_d     = PH_LINK;
					add_char = !is_quote(b);
				end
			end
			PH_LINK: begin
				if (qt_q ? is_quote(b) : (is_blank(b) || b == CH_GT)) begin
					term_hit = 1'b1;
					ph_d     = PH_IDLE;
				end else begin
					add_char = 1'b1;
				end
			end
			default: begin
				ph_d = rescan(b);
			end
		endcase

		// Link character bookkeeping
		if (add_char) begin
			if (run_d == '0) begin
				st_d = off_q;
				hf_d = (b == CH_HASH);
			end
			if (run_d != LEN_MAX) begin
				run_d = run_d + 1'b1;
			end
			if (!sm_d && sp_d < SCRIPT_LEN) begin
				if (b_lc == script_char(sp_d)) begin
					sp_d = sp_d + 4'd1;
				end else begin
					sm_d = 1'b1;
				end
			end
		end

		// Emit on a terminator, or at document end with a link open
		is_script = !sm_d && (sp_d >= SCRIPT_LEN);
		emit_hit  = term_hit || (item.last_byte && ph_d == PH_LINK);
		res_valid = take && emit_hit && (run_d != '0) && !hf_d && !is_script;
		res.link_start  = st_d;
		res.link_length = run_d;
		res.link_quoted = qt_d;
	end

	// State registers; document end returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			off_q <= '0;
			st_q  <= '0;
			run_q <= '0;
			qt_q  <= 1'b0;
			kp_q  <= '0;
			sp_q  <= '0;
			sm_q  <= 1'b0;
			hf_q  <= 1'b0;
		end else if (take) begin
			if (item.last_byte) begin
				ph_q  <= PH_IDLE;
				off_q <= '0;
				st_q  <= '0;
				run_q <= '0;
				qt_q  <= 1'b0;
				kp_q  <= '0;
				sp_q  <= '0;
				sm_q  <= 1'b0;
				hf_q  <= 1'b0;
			end else begin
				ph_q  <= ph_d;
				st_q  <= st_d;
				run_q <= run_d;
				qt_q  <= qt_d;
				kp_q  <= kp_d;
				sp_q  <= sp_d;
				sm_q  <= sm_d;
				hf_q  <= hf_d;
				if (off_q != OFF_MAX) begin
					off_q <= off_q + 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	// keyword progress only lives inside the href match
	assert property (@(posedge clk) disable iff (!arst_n)
		(kp_q != 2'd0) |-> (ph_q == PH_KEY))
		else $error("href progress outside keyword phase");

	// javascript progress never runs past the word
	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SCRIPT_LEN)
		else $error("script progress overflow");

	// document end clears the offset
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.last_byte) |=> (off_q == '0 && ph_q == PH_IDLE))
		else $error("state not cleared after document end");
`endif

endmodule

`default_nettype wire

// ===== rtl/html_href_link_extractor.sv =====
// Top level of the href link extractor: input handshake, byte scanner and
// output register with skid stage. Depends on hlx_pkg and hlx_scan.
//
// Usage:
//   item channel: one document byte per transaction (data_byte, last_byte),
//   accepted when item_valid is high and item_stall is low.
//   link channel: one transaction per reported link (link_start,
//   link_length, link_quoted), taken when link_valid is high and link_stall
//   is low.
//   Throughput: one byte per cycle while item_stall is low. The scanner
//   updates its phase and link registers in the cycle a byte is accepted.
//   Output: the byte that closes a link (its terminator, or the byte
//   flagged last_byte) loads it into the output or skid register.
//   Stall: a result held by link_stall is kept in the output register; one
//   more result fits in the skid register, after which item_stall rises
//   until the output drains.
//   Reset: arst_n clears the scan phase, byte offset and both output slots;
//   the block is ready for a new document right after reset, and again
//   after every byte flagged last_byte.
`default_nettype none

module html_href_link_extractor (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             item_valid,
	output logic            item_stall,
	input  wire hlx_pkg::item_t item,
	output logic            link_valid,
	input  wire             link_stall,
	output hlx_pkg::link_t  link
);
	import hlx_pkg::*;

	logic  take;
	logic  res_valid;
	link_t res;

	logic  out_valid_q;
	link_t out_q;
	logic  skid_valid_q;
	link_t skid_q;
	logic  out_free;

	assign item_stall = skid_valid_q;
	assign take       = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !link_stall;
	assign link_valid = out_valid_q;
	assign link       = out_q;

	hlx_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output and skid valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output and skid payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

`ifndef SYNTHESIS
	// skid holds data only behind a full output register
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid full while output empty");

	// a new result never arrives while the skid is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !res_valid)
		else $error("result produced with skid full");

	// reported links are never empty
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.link_length != '0))
		else $error("empty link reported");
`endif

endmodule

`default_nettype wire
